// ----- rtl/mp2w_pkg.sv -----
// Shared package for the 2-D max pooling window block.
// Holds field widths, register reset values, register indexes, FSM state and
// the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package mp2w_pkg;

   localparam int PIXEL_BITS_DEF = 32;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_WINDOW_DEF = 8;
   localparam int MAX_HEIGHT     = 1024;

   localparam int PIXEL_W    = 32;
   localparam int POOL_W     = 31;
   localparam int POS_W      = 10;
   localparam int DIM_W      = 11;
   localparam int WIN_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd1024;
   localparam logic [WIN_W-1:0] WINDOW_SIZE_RST  = 4'd2;
   localparam logic [WIN_W-1:0] STRIDE_RST       = 4'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_WINDOW_SIZE  = 2'd2,
      CSR_STRIDE       = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic scan;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic hit;
      logic scan_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- rtl/mp2w_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Stands alone; no package needed.
`default_nettype none

module mp2w_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/mp2w_ctrl.sv -----
// Controller FSM for the max pooling window block.
// Depends on mp2w_pkg; drives the datapath through ctrl_cmd_type.
`default_nettype none

module mp2w_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire mp2w_pkg::dp_status_type status,
   output mp2w_pkg::ctrl_cmd_type      cmd
);

   import mp2w_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.hit) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/mp2w_datapath.sv -----
// Datapath: registers, raster position, line store, window scan and output word.
// Depends on mp2w_pkg and mp2w_ram; commanded by mp2w_ctrl.
`default_nettype none

module mp2w_datapath #(
   parameter int PIXEL_BITS = mp2w_pkg::PIXEL_BITS_DEF,
   parameter int MAX_WIDTH  = mp2w_pkg::MAX_WIDTH_DEF,
   parameter int MAX_WINDOW = mp2w_pkg::MAX_WINDOW_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [mp2w_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [mp2w_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   input  wire logic signed [mp2w_pkg::PIXEL_W-1:0] req_pixel,
   input  wire logic                                rsp_stall,
   input  wire mp2w_pkg::ctrl_cmd_type              cmd,
   output mp2w_pkg::dp_status_type                  status,
   output logic                                     rsp_valid,
   output logic [mp2w_pkg::POOL_W-1:0]              rsp_pooled_max,
   output logic [mp2w_pkg::POS_W-1:0]               rsp_out_row,
   output logic [mp2w_pkg::POS_W-1:0]               rsp_out_col,
   output logic                                     rsp_frame_last
);

   import mp2w_pkg::*;

   localparam int DW    = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;
   localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int BW    = AW + 1;
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WSW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW + 1) : 1;
   localparam int WSX   = WIN_W + 1;
   localparam int CMPW  = ((CW > DIM_W) ? CW : DIM_W) + 2;

   // configuration registers
   logic [DIM_W-1:0] frame_width_ff, frame_width_in;
   logic [DIM_W-1:0] frame_height_ff, frame_height_in;
   logic [WIN_W-1:0] win_side_ff, win_side_in;
   logic [WIN_W-1:0] stride_ff, stride_in;

   // raster position
   logic [CW-1:0]    col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic [WIN_W-1:0] col_ph_ff, col_ph_in;
   logic [WIN_W-1:0] row_ph_ff, row_ph_in;
   logic [CW-1:0]    col_idx_ff, col_idx_in;
   logic [POS_W-1:0] row_idx_ff, row_idx_in;
   logic [AW-1:0]    base_ff, base_in;

   // window scan
   logic [AW-1:0]        scan_base_ff, scan_base_in;
   logic [CW-1:0]        scan_col_ff, scan_col_in;
   logic [WSW-1:0]       scan_k_ff, scan_k_in;
   logic [WSW-1:0]       scan_l_ff, scan_l_in;
   logic [POS_W-1:0]     hold_row_ff, hold_row_in;
   logic [CW-1:0]        hold_col_ff, hold_col_in;
   logic                 hold_last_ff, hold_last_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic signed [DW-1:0] best_ff, best_in;

   // output word
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POOL_W-1:0] rsp_pooled_max_ff, rsp_pooled_max_in;
   logic [POS_W-1:0]  rsp_out_row_ff, rsp_out_row_in;
   logic [POS_W-1:0]  rsp_out_col_ff, rsp_out_col_in;
   logic              rsp_frame_last_ff, rsp_frame_last_in;

   logic [CMPW-1:0]      w_eff, h_eff, ws_ext, s_ext, c1, r1;
   logic [WSX-1:0]       ws_wide;
   logic [WSW-1:0]       ws, ws_m1;
   logic [WIN_W-1:0]     s, s_m1;
   logic                 hit, last, col_wrap, row_wrap;
   logic [BW-1:0]        off, org_base_w, next_base_w, next_scan_w;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [DW-1:0]        rd_data_raw;
   logic signed [DW-1:0] rd_data;
   logic                 scan_last;

   // effective settings
   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = CMPW'(1);
      end else if (CMPW'(frame_width_ff) > CMPW'(MAX_WIDTH)) begin
         w_eff = CMPW'(MAX_WIDTH);
      end else begin
         w_eff = CMPW'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         h_eff = CMPW'(1);
      end else if (CMPW'(frame_height_ff) > CMPW'(MAX_HEIGHT)) begin
         h_eff = CMPW'(MAX_HEIGHT);
      end else begin
         h_eff = CMPW'(frame_height_ff);
      end
      if (win_side_ff == '0) begin
         ws_wide = WSX'(1);
      end else if (WSX'(win_side_ff) > WSX'(MAX_WINDOW)) begin
         ws_wide = WSX'(MAX_WINDOW);
      end else begin
         ws_wide = WSX'(win_side_ff);
      end
      ws     = WSW'(ws_wide);
      ws_m1  = ws - WSW'(1);
      ws_ext = CMPW'(ws);
      s      = (stride_ff == '0) ? WIN_W'(1) : stride_ff;
      s_m1   = s - WIN_W'(1);
      s_ext  = CMPW'(s);
   end

   assign c1       = CMPW'(col_ff) + CMPW'(1);
   assign r1       = CMPW'(row_ff) + CMPW'(1);
   assign col_wrap = (c1 >= w_eff);
   assign row_wrap = (r1 >= h_eff);
   assign hit      = (c1 >= ws_ext) && (r1 >= ws_ext) &&
                     (col_ph_ff == '0) && (row_ph_ff == '0);
   assign last     = ((c1 + s_ext) > w_eff) && ((r1 + s_ext) > h_eff);

   assign off         = BW'(ws_m1) * BW'(MAX_WIDTH);
   assign org_base_w  = (BW'(base_ff) >= off) ? (BW'(base_ff) - off)
                                              : (BW'(base_ff) + BW'(DEPTH) - off);
   assign next_base_w = BW'(base_ff) + BW'(MAX_WIDTH);
   assign next_scan_w = BW'(scan_base_ff) + BW'(MAX_WIDTH);

   assign wr_addr   = base_ff + AW'(col_ff);
   assign rd_addr   = scan_base_ff + AW'(scan_col_ff) + AW'(scan_l_ff);
   assign rd_data   = $signed(rd_data_raw);
   assign scan_last = (scan_k_ff == ws_m1) && (scan_l_ff == ws_m1);

   assign status.hit       = hit;
   assign status.scan_last = scan_last;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // configuration and raster position
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      win_side_in     = win_side_ff;
      stride_in       = stride_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      col_ph_in       = col_ph_ff;
      row_ph_in       = row_ph_ff;
      col_idx_in      = col_idx_ff;
      row_idx_in      = row_idx_ff;
      base_in         = base_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wr_data[DIM_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_in = csr_wr_data[DIM_W-1:0];
            CSR_WINDOW_SIZE:  win_side_in     = csr_wr_data[WIN_W-1:0];
            CSR_STRIDE:       stride_in       = csr_wr_data[WIN_W-1:0];
            default: begin
            end
         endcase
         col_in     = '0;
         row_in     = '0;
         col_ph_in  = '0;
         row_ph_in  = '0;
         col_idx_in = '0;
         row_idx_in = '0;
         base_in    = '0;
      end else if (cmd.accept) begin
         if (col_wrap) begin
            col_in     = '0;
            col_ph_in  = '0;
            col_idx_in = '0;
            if (row_wrap) begin
               row_in     = '0;
               row_ph_in  = '0;
               row_idx_in = '0;
               base_in    = '0;
            end else begin
               row_in  = row_ff + POS_W'(1);
               base_in = (next_base_w >= BW'(DEPTH)) ? '0 : AW'(next_base_w);
               if (r1 < ws_ext) begin
                  row_ph_in  = '0;
                  row_idx_in = '0;
               end else if (row_ph_ff == s_m1) begin
                  row_ph_in  = '0;
                  row_idx_in = row_idx_ff + POS_W'(1);
               end else begin
                  row_ph_in = row_ph_ff + WIN_W'(1);
               end
            end
         end else begin
            col_in = col_ff + CW'(1);
            if (c1 < ws_ext) begin
               col_ph_in  = '0;
               col_idx_in = '0;
            end else if (col_ph_ff == s_m1) begin
               col_ph_in  = '0;
               col_idx_in = col_idx_ff + CW'(1);
            end else begin
               col_ph_in = col_ph_ff + WIN_W'(1);
            end
         end
      end
   end

   // window scan and output word
   always_comb begin
      scan_base_in      = scan_base_ff;
      scan_col_in       = scan_col_ff;
      scan_k_in         = scan_k_ff;
      scan_l_in         = scan_l_ff;
      hold_row_in       = hold_row_ff;
      hold_col_in       = hold_col_ff;
      hold_last_in      = hold_last_ff;
      best_in           = best_ff;
      rd_vld_in         = cmd.scan;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_pooled_max_in = rsp_pooled_max_ff;
      rsp_out_row_in    = rsp_out_row_ff;
      rsp_out_col_in    = rsp_out_col_ff;
      rsp_frame_last_in = rsp_frame_last_ff;
      if (cmd.accept) begin
         scan_base_in = AW'(org_base_w);
         scan_col_in  = CW'(c1 - ws_ext);
         scan_k_in    = '0;
         scan_l_in    = '0;
         hold_row_in  = row_idx_ff;
         hold_col_in  = col_idx_ff;
         hold_last_in = last;
         best_in      = '0;
      end
      if (cmd.scan) begin
         if (scan_l_ff == ws_m1) begin
            scan_l_in    = '0;
            scan_k_in    = scan_k_ff + WSW'(1);
            scan_base_in = (next_scan_w >= BW'(DEPTH)) ? '0 : AW'(next_scan_w);
         end else begin
            scan_l_in = scan_l_ff + WSW'(1);
         end
      end
      if (rd_vld_ff && (rd_data >= best_ff)) begin
         best_in = rd_data;
      end
      if (cmd.load_out) begin
         rsp_valid_in      = 1'b1;
         rsp_pooled_max_in = POOL_W'($unsigned(best_ff));
         rsp_out_row_in    = hold_row_ff;
         rsp_out_col_in    = POS_W'(hold_col_ff);
         rsp_frame_last_in = hold_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         win_side_ff     <= WINDOW_SIZE_RST;
         stride_ff       <= STRIDE_RST;
         col_ff          <= '0;
         row_ff          <= '0;
         col_ph_ff       <= '0;
         row_ph_ff       <= '0;
         col_idx_ff      <= '0;
         row_idx_ff      <= '0;
         base_ff         <= '0;
         rd_vld_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         win_side_ff     <= win_side_in;
         stride_ff       <= stride_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         col_ph_ff       <= col_ph_in;
         row_ph_ff       <= row_ph_in;
         col_idx_ff      <= col_idx_in;
         row_idx_ff      <= row_idx_in;
         base_ff         <= base_in;
         rd_vld_ff       <= rd_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_base_ff      <= scan_base_in;
      scan_col_ff       <= scan_col_in;
      scan_k_ff         <= scan_k_in;
      scan_l_ff         <= scan_l_in;
      hold_row_ff       <= hold_row_in;
      hold_col_ff       <= hold_col_in;
      hold_last_ff      <= hold_last_in;
      best_ff           <= best_in;
      rsp_pooled_max_ff <= rsp_pooled_max_in;
      rsp_out_row_ff    <= rsp_out_row_in;
      rsp_out_col_ff    <= rsp_out_col_in;
      rsp_frame_last_ff <= rsp_frame_last_in;
   end

   mp2w_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (cmd.accept),
      .wr_addr (wr_addr),
      .wr_data (req_pixel[DW-1:0]),
      .rd_en   (cmd.scan),
      .rd_addr (rd_addr),
      .rd_data (rd_data_raw)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pooled_max = rsp_pooled_max_ff;
   assign rsp_out_row    = rsp_out_row_ff;
   assign rsp_out_col    = rsp_out_col_ff;
   assign rsp_frame_last = rsp_frame_last_ff;

endmodule

`default_nettype wire

// ----- rtl/max_pool_2d_window.sv -----
// Top level of the 2-D max pooling window block: controller plus datapath.
// Depends on mp2w_pkg, mp2w_ctrl, mp2w_datapath (and mp2w_ram below it).
// Usage:
//   req_* takes one signed pixel per word in raster order; rsp_* gives one word
//   per completed pooling window: the window maximum (floored at zero), the
//   pooled row and column, and a flag on the final window of the frame.
//   csr_* writes frame width (0), frame height (1), window side (2), stride (3);
//   any write restarts the frame at row 0, column 0. Write only when idle.
// Window scan:
//   A pixel that completes no window is taken without a stall. A pixel that
//   completes a window holds req_stall while the line store is read one entry
//   per cycle through its single read port, and through the drain and finish
//   states after it; the finish state waits for a free output register.
// Reset:
//   Synchronous, active high. Registers return to 1024, 1024, 2, 2, position
//   to the frame origin and the output register empties. The line store is
//   not cleared; no entry is read before it is written.
// Stall:
//   The output register holds its word while rsp_stall is high; the next
//   pixel is still taken, and a finished window waits until the word leaves.
`default_nettype none

module max_pool_2d_window #(
   parameter int PIXEL_BITS = mp2w_pkg::PIXEL_BITS_DEF,
   parameter int MAX_WIDTH  = mp2w_pkg::MAX_WIDTH_DEF,
   parameter int MAX_WINDOW = mp2w_pkg::MAX_WINDOW_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [mp2w_pkg::PIXEL_W-1:0] req_pixel,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [mp2w_pkg::POOL_W-1:0]              rsp_pooled_max,
   output logic [mp2w_pkg::POS_W-1:0]               rsp_out_row,
   output logic [mp2w_pkg::POS_W-1:0]               rsp_out_col,
   output logic                                     rsp_frame_last,
   input  wire logic                                csr_wr_en,
   input  wire logic [mp2w_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [mp2w_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   import mp2w_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   mp2w_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mp2w_datapath #(
      .PIXEL_BITS (PIXEL_BITS),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req_pixel      (req_pixel),
      .rsp_stall      (rsp_stall),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_pooled_max (rsp_pooled_max),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

`default_nettype wire

// ----- rtl/mp2w_checker.sv -----
// Port-level checks for max_pool_2d_window, attached by bind.
// Depends on mp2w_pkg for port widths.
`default_nettype none

module mp2w_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic [mp2w_pkg::POOL_W-1:0]         rsp_pooled_max,
   input wire logic [mp2w_pkg::POS_W-1:0]          rsp_out_row,
   input wire logic [mp2w_pkg::POS_W-1:0]          rsp_out_col,
   input wire logic                                rsp_frame_last
);

   import mp2w_pkg::*;

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pooled_max) &&
      $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_frame_last))
      else $error("stalled result word changed");

   // a new result word only appears at the end of a window scan
   a_rsp_after_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result word appeared outside a window scan");

   // no result word in the cycle straight after a pixel is taken
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result word appeared without a window scan");

endmodule

bind max_pool_2d_window mp2w_checker u_checker (.*);

`default_nettype wire

// ----- tb/max_pool_2d_window_checker.sv -----
// Checker for max_pool_2d_window: watches the pixel, result and register ports,
// pools each accepted pixel in its own line store and compares every result word.
// Depends on mp2w_pkg for field widths, register indexes and reset values.
module max_pool_2d_window_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  wire logic signed [mp2w_pkg::PIXEL_W-1:0] req_pixel,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   input  wire logic [mp2w_pkg::POOL_W-1:0]         rsp_pooled_max,
   input  wire logic [mp2w_pkg::POS_W-1:0]          rsp_out_row,
   input  wire logic [mp2w_pkg::POS_W-1:0]          rsp_out_col,
   input  wire logic                                rsp_frame_last,
   input  wire logic                                csr_wr_en,
   input  wire logic [mp2w_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [mp2w_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   output int                                       pending,
   output int                                       fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import mp2w_pkg::*;

   typedef struct packed {
      logic [POOL_W-1:0] pooled_max;
      logic [POS_W-1:0]  out_row;
      logic [POS_W-1:0]  out_col;
      logic              frame_last;
   } pool_word_type;

   pool_word_type             pending_windows[$];
   logic [DIM_W-1:0]          width_reg;
   logic [DIM_W-1:0]          height_reg;
   logic [WIN_W-1:0]          window_reg;
   logic [WIN_W-1:0]          stride_reg;
   int                        row_pos;
   int                        col_pos;
   int                        errors = 0;
   logic signed [PIXEL_W-1:0] line_store [MAX_WINDOW_DEF * MAX_WIDTH_DEF];

   function automatic int clamp(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic store_and_pool(input logic signed [PIXEL_W-1:0] px);
      int                        w, h, ws, s, r, c, org_r, org_c, k, l;
      logic signed [PIXEL_W-1:0] best;
      logic signed [PIXEL_W-1:0] v;
      pool_word_type             word;
      w = clamp(int'(width_reg), 1, MAX_WIDTH_DEF);
      h = clamp(int'(height_reg), 1, MAX_HEIGHT);
      ws = clamp(int'(window_reg), 1, MAX_WINDOW_DEF);
      s = (stride_reg == '0) ? 1 : int'(stride_reg);
      r = (row_pos >= h) ? 0 : row_pos;
      c = (col_pos >= w) ? 0 : col_pos;
      line_store[(r % MAX_WINDOW_DEF) * MAX_WIDTH_DEF + c] = px;
      if (r + 1 >= ws && c + 1 >= ws) begin
         org_r = r + 1 - ws;
         org_c = c + 1 - ws;
         if (org_r % s == 0 && org_c % s == 0) begin
            best = '0;
            for (k = 0; k < ws; k++) begin
               for (l = 0; l < ws; l++) begin
                  v = line_store[((org_r + k) % MAX_WINDOW_DEF) * MAX_WIDTH_DEF + org_c + l];
                  if (v >= best) best = v;
               end
            end
            word.pooled_max = best[POOL_W-1:0];
            word.out_row    = POS_W'(org_r / s);
            word.out_col    = POS_W'(org_c / s);
            word.frame_last = (org_r / s == (h - ws) / s) && (org_c / s == (w - ws) / s);
            pending_windows.push_back(word);
         end
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      row_pos = r;
      col_pos = c;
   endtask

   task automatic match_window();
      pool_word_type want;
      if (pending_windows.size() == 0) begin
         $error("result word with no window pending: max %0d row %0d col %0d last %0b",
                rsp_pooled_max, rsp_out_row, rsp_out_col, rsp_frame_last);
         errors++;
         return;
      end
      want = pending_windows.pop_front();
      if (rsp_pooled_max !== want.pooled_max) begin
         $error("pooled_max: expected %0d, actual %0d", want.pooled_max, rsp_pooled_max);
         errors++;
      end
      if (rsp_out_row !== want.out_row) begin
         $error("out_row: expected %0d, actual %0d", want.out_row, rsp_out_row);
         errors++;
      end
      if (rsp_out_col !== want.out_col) begin
         $error("out_col: expected %0d, actual %0d", want.out_col, rsp_out_col);
         errors++;
      end
      if (rsp_frame_last !== want.frame_last) begin
         $error("frame_last: expected %0b, actual %0b", want.frame_last, rsp_frame_last);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg  = FRAME_WIDTH_RST;
         height_reg = FRAME_HEIGHT_RST;
         window_reg = WINDOW_SIZE_RST;
         stride_reg = STRIDE_RST;
         row_pos    = 0;
         col_pos    = 0;
         pending_windows.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_FRAME_WIDTH:  width_reg  = csr_wr_data;
               CSR_FRAME_HEIGHT: height_reg = csr_wr_data;
               CSR_WINDOW_SIZE:  window_reg = csr_wr_data[WIN_W-1:0];
               CSR_STRIDE:       stride_reg = csr_wr_data[WIN_W-1:0];
               default: ;
            endcase
            row_pos = 0;
            col_pos = 0;
         end
         if (rsp_valid && !rsp_stall) match_window();
         if (req_valid && !req_stall) store_and_pool(req_pixel);
      end
      pending    <= pending_windows.size();
      fail_count <= errors;
   end

endmodule

// ----- tb/max_pool_2d_window_tb.sv -----
// Top of the max_pool_2d_window testbench: clock, reset, pixel and register stimulus.
// Instantiates the block and max_pool_2d_window_checker; depends on mp2w_pkg.
module max_pool_2d_window_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mp2w_pkg::*;

   logic                      clock;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic signed [PIXEL_W-1:0] req_pixel   = '0;
   logic                      rsp_stall   = 1'b0;
   logic                      csr_wr_en   = 1'b0;
   csr_index_type             csr_index   = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0]     csr_wr_data = '0;

   wire logic                 req_stall;
   wire logic                 rsp_valid;
   wire logic [POOL_W-1:0]    rsp_pooled_max;
   wire logic [POS_W-1:0]     rsp_out_row;
   wire logic [POS_W-1:0]     rsp_out_col;
   wire logic                 rsp_frame_last;

   int pending;
   int fail_count;
   int req_idle_pct  = 24;
   int rsp_idle_pct  = 50;
   int hold_request  = 0;
   int hold_served   = 0;

   max_pool_2d_window uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pooled_max (rsp_pooled_max),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_last (rsp_frame_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   max_pool_2d_window_checker pool_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pooled_max (rsp_pooled_max),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_last (rsp_frame_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .pending        (pending),
      .fail_count     (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("Some tests failed");
      $finish;
   end

   // hold the result side for a long stretch on request
   initial begin
      forever begin
         if (hold_request != hold_served) begin
            hold_served = hold_request;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
            @(posedge clock);
         end
      end
   end

   function automatic logic [PIXEL_W-1:0] rand_pixel();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($urandom_range(16));
         3: return 32'(0 - $urandom_range(16));
         4: return {1'b1, 31'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(input logic [PIXEL_W-1:0] px);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic stream_pixels(input int count, input int pause_at);
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending != 0);
         end
         send_word(rand_pixel());
      end
      req_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock); while (pending != 0);
      repeat (80) @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] w, h, ws, s);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_FRAME_WIDTH;
      csr_wr_data <= w;
      @(posedge clock);
      csr_index   <= CSR_FRAME_HEIGHT;
      csr_wr_data <= h;
      @(posedge clock);
      csr_index   <= CSR_WINDOW_SIZE;
      csr_wr_data <= ws;
      @(posedge clock);
      csr_index   <= CSR_STRIDE;
      csr_wr_data <= s;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_random(input int target);
      int sent;
      int w, h, ws, s, n;
      sent = 0;
      while (sent < target) begin
         case ($urandom_range(9))
            0: begin
               w  = $urandom_range(1, 4);
               h  = $urandom_range(1, 4);
               ws = $urandom_range(5, 8);
               s  = $urandom_range(0, 15);
               n  = $urandom_range(1, 20);
            end
            1: begin
               ws = $urandom_range(1, 8);
               w  = ws + $urandom_range(0, 6);
               h  = ws + $urandom_range(0, 6);
               s  = $urandom_range(1, 8);
               n  = w * h;
            end
            2: begin
               w  = $urandom_range(0, 2047);
               h  = $urandom_range(0, 2047);
               ws = {$urandom_range(0, 127), 4'($urandom_range(0, 15))};
               s  = {$urandom_range(0, 127), 4'($urandom_range(0, 15))};
               n  = $urandom_range(1, 40);
            end
            default: begin
               w  = $urandom_range(1, 10);
               h  = $urandom_range(1, 10);
               ws = $urandom_range(1, 4);
               s  = $urandom_range(1, 4);
               n  = w * h * $urandom_range(1, 2);
               if ($urandom_range(3) == 0) n += $urandom_range(0, w * h - 1);
            end
         endcase
         configure(CSR_DATA_W'(w), CSR_DATA_W'(h), CSR_DATA_W'(ws), CSR_DATA_W'(s));
         stream_pixels(n, -1);
         wait_idle();
         sent += n;
      end
   endtask

   initial begin
      logic [PIXEL_W-1:0] edge_px [9];
      edge_px = '{32'h7FFF_FFFF, -32'sd5, -32'sd7,
                  32'h8000_0000, -32'sd1, -32'sd2,
                  32'h0000_0000, -32'sd3, -32'sd4};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, all-negative windows and zero against negatives
      configure(11'd3, 11'd3, 11'd2, 11'd1);
      foreach (edge_px[i]) send_word(edge_px[i]);
      req_valid <= 1'b0;
      wait_idle();
      // window larger than frame
      configure(11'd2, 11'd2, 11'd3, 11'd1);
      stream_pixels(4, -1);
      wait_idle();
      // zero registers saturate up, oversized height saturates down
      configure(11'd0, 11'd2047, 11'd0, 11'd0);
      stream_pixels(4, -1);
      wait_idle();
      // oversized width and window, zero height
      configure(11'd2000, 11'd0, 11'd15, 11'd9);
      stream_pixels(3, -1);
      wait_idle();

      hold_request <= hold_request + 1;
      configure(11'd8, 11'd8, 11'd1, 11'd1);
      stream_pixels(64, -1);
      wait_idle();
      run_random(130);

      req_idle_pct = 50;
      rsp_idle_pct = 24;
      configure(11'd6, 11'd6, 11'd2, 11'd2);
      stream_pixels(36, 18);
      wait_idle();
      run_random(130);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      configure(11'd1024, 11'd1024, 11'd1, 11'd1);
      stream_pixels(290, -1);
      wait_idle();
      configure(11'd1, 11'd1024, 11'd1, 11'd1);
      stream_pixels(290, -1);
      wait_idle();
      run_random(130);

      wait_idle();
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
